// ===== design/lsx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsx_pkg: shared constants and functions of the shuffled XOR byte cipher
// Key permutation table, bit select masks, per-position XOR row, LCG step.
// ----------------------------------------------------------------------------
package lsx_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int TBL_AW     = $clog2(TABLE_SIZE);

    localparam logic [31:0] LCG_MUL = 32'h0003_43fd;
    localparam logic [31:0] LCG_ADD = 32'h0026_9ec3;

    localparam logic [7:0] BIT_SEL [8] = '{
        8'h81, 8'h40, 8'h22, 8'h10, 8'h0a, 8'h04, 8'h02, 8'h01
    };

    localparam logic [7:0] XOR_ROW [8] = '{
        8'h51, 8'hf3, 8'h4c, 8'hd7, 8'h89, 8'hab, 8'h20, 8'h6e
    };

    localparam logic [5:0] PERM_SRC [64] = '{
        6'h07, 6'h18, 6'h10, 6'h0b, 6'h2b, 6'h23, 6'h0f, 6'h17,
        6'h3c, 6'h05, 6'h36, 6'h2e, 6'h01, 6'h1e, 6'h04, 6'h0e,
        6'h3b, 6'h30, 6'h1f, 6'h0c, 6'h16, 6'h1b, 6'h03, 6'h00,
        6'h2c, 6'h24, 6'h38, 6'h33, 6'h27, 6'h39, 6'h31, 6'h29,
        6'h37, 6'h3f, 6'h1c, 6'h13, 6'h3d, 6'h08, 6'h3e, 6'h0d,
        6'h06, 6'h35, 6'h2d, 6'h25, 6'h26, 6'h1d, 6'h15, 6'h34,
        6'h22, 6'h1a, 6'h28, 6'h20, 6'h12, 6'h21, 6'h19, 6'h2f,
        6'h11, 6'h09, 6'h3a, 6'h32, 6'h2a, 6'h0a, 6'h02, 6'h14
    };

    // Byte n of a 64-bit word, byte 0 in the top bits
    function automatic logic [7:0] word_byte(input logic [63:0] w, input logic [2:0] n);
        return w[63 - 8 * int'(n) -: 8];
    endfunction

    function automatic logic [63:0] permute_key(input logic [63:0] k);
        logic [63:0] res;
        logic [5:0]  src;
        logic [7:0]  b;
        res = '0;
        for (int i = 0; i < 64; i++)
        begin
            src = PERM_SRC[i];
            b   = word_byte(k, src[5:3]);
            res[56 - 8 * (i / 8) + (i % 8)] = |(b & BIT_SEL[src[2:0]]);
        end
        return res;
    endfunction

    function automatic logic [7:0] rotr8(input logic [7:0] v, input logic [2:0] r);
        logic [15:0] dbl;
        dbl = {v, v} >> r;
        return dbl[7:0];
    endfunction

    function automatic logic [31:0] lcg_next(input logic [31:0] s);
        return s * LCG_MUL + LCG_ADD;
    endfunction

endpackage

// ===== design/lsx_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsx_ram: generic RAM, one write port, two registered read ports
// Read data holds until the next enabled read on that port.
// ----------------------------------------------------------------------------
module lsx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic                     re_b,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== design/lcg_shuffled_xor_block_cipher_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_shuffled_xor_block_cipher_top: LCG-shuffled XOR byte cipher
// Data items: one per cycle unless in_stall or out_stall holds them; each
//   result passes the table read, then the output register. A start item
//   builds the schedule: 256 identity writes, then 256 swaps on the table RAM.
// Reset clears key, permuted key, position and block count; the table is
//   undefined until the first start item fills it.
// ----------------------------------------------------------------------------
module lcg_shuffled_xor_block_cipher_top
    import lsx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        key_we,
    input  logic [63:0] key,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [15:0] message_length,
    input  logic [7:0]  data_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  data_out,
    output logic        in_tail,
    output logic        overrun
);

    localparam logic CMD_START = 1'b0;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FILL = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_WR_I = 3'd3;
    localparam logic [2:0] ST_WR_J = 3'd4;

    localparam logic [TBL_AW-1:0] IDX_LAST = TBL_AW'(TABLE_SIZE - 1);

    logic [63:0]       key_reg;
    logic [63:0]       pkey_reg;
    logic [15:0]       pos_reg;
    logic [15:0]       fbb_reg;
    logic [2:0]        state_reg;
    logic [TBL_AW-1:0] idx_reg;
    logic [31:0]       seed_reg;

    logic              s1_valid_reg;
    logic [7:0]        s1_din_reg;
    logic              s1_tail_reg;
    logic              s1_over_reg;
    logic [2:0]        s1_r_reg;

    logic              out_valid_reg;
    logic [7:0]        dout_reg;
    logic              tail_reg;
    logic              over_reg;

    logic              s1_adv;
    logic              accept;
    logic              start_acc;
    logic              data_acc;
    logic              cur_tail;
    logic              cur_over;

    logic              ram_we;
    logic [TBL_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re_a;
    logic [TBL_AW-1:0] ram_raddr_a;
    logic [7:0]        ram_rdata_a;
    logic [7:0]        ram_rdata_b;
    logic [TBL_AW-1:0] j_idx;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    // Start waits for an empty table-read stage so the table and key stay put
    assign in_stall  = (state_reg != ST_IDLE) ||
                       (s1_valid_reg && ((cmd == CMD_START) || !s1_adv));
    assign accept    = in_valid && !in_stall;
    assign start_acc = accept && (cmd == CMD_START);
    assign data_acc  = accept && (cmd != CMD_START);

    assign cur_tail  = (pos_reg >= fbb_reg);
    assign cur_over  = !cur_tail && (pos_reg[15:TBL_AW] != '0);

    assign j_idx     = seed_reg[16 +: TBL_AW];

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = ram_rdata_b;
        case (state_reg)
            ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_wdata = 8'(idx_reg);
            end
            ST_WR_I:
            begin
                ram_we = 1'b1;
            end
            ST_WR_J:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_idx;
                ram_wdata = ram_rdata_a;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign ram_re_a    = (state_reg == ST_READ) || data_acc;
    assign ram_raddr_a = (state_reg == ST_IDLE) ? pos_reg[TBL_AW-1:0] : idx_reg;

    lsx_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re_a    (ram_re_a),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .re_b    (state_reg == ST_READ),
        .raddr_b (j_idx),
        .rdata_b (ram_rdata_b)
    );

    // Control and schedule state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg       <= '0;
            pkey_reg      <= '0;
            pos_reg       <= '0;
            fbb_reg       <= '0;
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            seed_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (key_we)
            begin
                key_reg <= key;
            end

            if (start_acc)
            begin
                pkey_reg  <= permute_key(key_reg);
                fbb_reg   <= {message_length[15:3], 3'b000};
                pos_reg   <= '0;
                seed_reg  <= lcg_next(key_reg[63:32] ^ key_reg[31:0]);
                idx_reg   <= '0;
                state_reg <= ST_FILL;
            end
            else
            begin
                case (state_reg)
                    ST_FILL:
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg == IDX_LAST)
                        begin
                            state_reg <= ST_READ;
                        end
                    end
                    ST_READ:
                    begin
                        state_reg <= ST_WR_I;
                    end
                    ST_WR_I:
                    begin
                        state_reg <= ST_WR_J;
                    end
                    ST_WR_J:
                    begin
                        // advance LCG for the next swap
                        seed_reg <= lcg_next(seed_reg);
                        idx_reg  <= idx_reg + 1'b1;
                        if (idx_reg == IDX_LAST)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_READ;
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end

            // saturate position at the top
            if (data_acc && (pos_reg != 16'hffff))
            begin
                pos_reg <= pos_reg + 16'd1;
            end

            if (data_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (data_acc)
        begin
            s1_din_reg  <= data_in;
            s1_tail_reg <= cur_tail;
            s1_over_reg <= cur_over;
            s1_r_reg    <= pos_reg[2:0];
        end
        if (s1_adv)
        begin
            tail_reg <= s1_tail_reg;
            over_reg <= s1_over_reg;
            if (s1_tail_reg || s1_over_reg)
            begin
                dout_reg <= s1_din_reg;
            end
            else
            begin
                dout_reg <= s1_din_reg ^ ram_rdata_a ^
                            rotr8(word_byte(pkey_reg, s1_r_reg), s1_r_reg) ^
                            XOR_ROW[s1_r_reg];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = dout_reg;
    assign in_tail   = tail_reg;
    assign overrun   = over_reg;

endmodule

// ===== sim/tb_lcg_shuffled_xor_block_cipher_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lcg_shuffled_xor_block_cipher_top: self-checking bench of the byte cipher
// Runs a directed table, then random messages under several idle and stall
// mixes, a long receiver hold-off and one long message that runs past the
// end of the table. Every output byte is checked against a directed value
// or an in-bench model of the key permutation, LCG table shuffle and XOR path.
// ----------------------------------------------------------------------------
module tb_lcg_shuffled_xor_block_cipher_top
    import lsx_pkg::*;
();

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam int SCHED_CYCLES = 1100;   // schedule build plus margin
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int RAND_ITEMS   = 140;
    localparam int LONG_BYTES   = 272;

    localparam logic [7:0] MASK_ROW [8] = '{
        8'h81, 8'h40, 8'h22, 8'h10, 8'h0a, 8'h04, 8'h02, 8'h01
    };
    localparam logic [7:0] XOR_C [8] = '{
        8'h51, 8'hf3, 8'h4c, 8'hd7, 8'h89, 8'hab, 8'h20, 8'h6e
    };
    localparam logic [5:0] KEY_PERM [64] = '{
        6'h07, 6'h18, 6'h10, 6'h0b, 6'h2b, 6'h23, 6'h0f, 6'h17,
        6'h3c, 6'h05, 6'h36, 6'h2e, 6'h01, 6'h1e, 6'h04, 6'h0e,
        6'h3b, 6'h30, 6'h1f, 6'h0c, 6'h16, 6'h1b, 6'h03, 6'h00,
        6'h2c, 6'h24, 6'h38, 6'h33, 6'h27, 6'h39, 6'h31, 6'h29,
        6'h37, 6'h3f, 6'h1c, 6'h13, 6'h3d, 6'h08, 6'h3e, 6'h0d,
        6'h06, 6'h35, 6'h2d, 6'h25, 6'h26, 6'h1d, 6'h15, 6'h34,
        6'h22, 6'h1a, 6'h28, 6'h20, 6'h12, 6'h21, 6'h19, 6'h2f,
        6'h11, 6'h09, 6'h3a, 6'h32, 6'h2a, 6'h0a, 6'h02, 6'h14
    };

    typedef struct packed {
        logic [7:0] dout;
        logic       tail;
        logic       over;
    } byte_result_t;

    typedef enum logic [1:0] {ROW_KEY, ROW_START, ROW_BYTE, ROW_BYTE_EXP} row_kind_t;

    typedef struct packed {
        row_kind_t    kind;
        logic [63:0]  arg;
        byte_result_t res;
    } dir_row_t;

    localparam int DIR_N = 24;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        // bytes before any start are tail
        '{ROW_BYTE_EXP, 64'h00, '{8'h00, 1'b1, 1'b0}},
        '{ROW_BYTE_EXP, 64'hff, '{8'hff, 1'b1, 1'b0}},
        // zero length: all tail
        '{ROW_START,    64'h0000, '{8'h00, 1'b0, 1'b0}},
        '{ROW_BYTE_EXP, 64'ha5, '{8'ha5, 1'b1, 1'b0}},
        // length below one block
        '{ROW_START,    64'h0007, '{8'h00, 1'b0, 1'b0}},
        '{ROW_BYTE_EXP, 64'h00, '{8'h00, 1'b1, 1'b0}},
        '{ROW_BYTE_EXP, 64'hff, '{8'hff, 1'b1, 1'b0}},
        '{ROW_START,    64'h0008, '{8'h00, 1'b0, 1'b0}},
        '{ROW_BYTE,     64'h00, '{8'h00, 1'b0, 1'b0}},
        '{ROW_BYTE,     64'hff, '{8'h00, 1'b0, 1'b0}},
        '{ROW_BYTE,     64'h3c, '{8'h00, 1'b0, 1'b0}},
        // restart in the middle of a message
        '{ROW_START,    64'h0010, '{8'h00, 1'b0, 1'b0}},
        '{ROW_BYTE,     64'h00, '{8'h00, 1'b0, 1'b0}},
        '{ROW_KEY,      64'hffff_ffff_ffff_ffff, '{8'h00, 1'b0, 1'b0}},
        '{ROW_START,    64'hffff, '{8'h00, 1'b0, 1'b0}},
        '{ROW_BYTE,     64'h00, '{8'h00, 1'b0, 1'b0}},
        '{ROW_BYTE,     64'hff, '{8'h00, 1'b0, 1'b0}},
        '{ROW_KEY,      64'h8000_0000_0000_0001, '{8'h00, 1'b0, 1'b0}},
        '{ROW_START,    64'hfff8, '{8'h00, 1'b0, 1'b0}},
        '{ROW_BYTE,     64'h7e, '{8'h00, 1'b0, 1'b0}},
        '{ROW_KEY,      64'h0123_4567_89ab_cdef, '{8'h00, 1'b0, 1'b0}},
        '{ROW_START,    64'h0009, '{8'h00, 1'b0, 1'b0}},
        '{ROW_BYTE,     64'h11, '{8'h00, 1'b0, 1'b0}},
        '{ROW_BYTE,     64'h80, '{8'h00, 1'b0, 1'b0}}
    };

    logic        clk;
    logic        rst_n;
    logic        key_we;
    logic [63:0] key;
    logic        in_valid;
    logic        in_stall;
    logic        cmd;
    logic [15:0] message_length;
    logic [7:0]  data_in;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  data_out;
    logic        in_tail;
    logic        overrun;

    // model state
    logic [63:0] key_reg;
    logic [63:0] perm_key;
    logic [7:0]  shuf [TABLE_SIZE];
    logic [15:0] msg_pos;
    logic [15:0] block_bytes;

    byte_result_t pending_bytes [$];

    int err_count;
    int sender_idle_pct;
    int stall_pct;
    int hold_req_cnt;
    int hold_ack_cnt;
    int hold_left;

    lcg_shuffled_xor_block_cipher_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .key_we         (key_we),
        .key            (key),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .message_length (message_length),
        .data_in        (data_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .data_out       (data_out),
        .in_tail        (in_tail),
        .overrun        (overrun)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < 40)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %02h want %02h", name, got, want));
    endtask

    task automatic build_schedule();
        logic [31:0] seed;
        logic [7:0]  t;
        logic [7:0]  j;
        logic [5:0]  src;
        perm_key = '0;
        for (int i = 0; i < 64; i++)
        begin
            src = KEY_PERM[i];
            if ((key_reg[63 - 8 * src[5:3] -: 8] & MASK_ROW[src[2:0]]) != 8'h00)
                perm_key[56 - 8 * (i / 8) + (i % 8)] = 1'b1;
        end
        for (int i = 0; i < TABLE_SIZE; i++)
            shuf[i] = 8'(i);
        seed = key_reg[63:32] ^ key_reg[31:0];
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            seed = seed * 32'h0003_43fd + 32'h0026_9ec3;
            j = seed[23:16];
            t = shuf[i];
            shuf[i] = shuf[j];
            shuf[j] = t;
        end
    endtask

    function automatic byte_result_t cipher_byte(input logic [7:0] din);
        byte_result_t res;
        logic [2:0]   r;
        logic [7:0]   v;
        logic [7:0]   rot;
        res.dout = din;
        res.tail = 1'b0;
        res.over = 1'b0;
        if (msg_pos >= block_bytes)
            res.tail = 1'b1;
        else if (msg_pos >= TABLE_SIZE)
            res.over = 1'b1;
        else
        begin
            r = msg_pos[2:0];
            v = perm_key[63 - 8 * r -: 8];
            rot = (v >> r) | (v << (4'd8 - r));
            res.dout = din ^ shuf[msg_pos[7:0]] ^ rot ^ XOR_C[r];
        end
        // saturate, never wrap
        if (msg_pos != 16'hffff)
            msg_pos = msg_pos + 16'd1;
        return res;
    endfunction

    // Offer one item, wait for accept, then record what it should produce.
    task automatic push_item(input logic c, input logic [15:0] len, input logic [7:0] d,
                             input bit typed, input byte_result_t typed_res);
        byte_result_t res;
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < sender_idle_pct);
        end
        in_valid       <= 1'b1;
        cmd            <= c;
        message_length <= len;
        data_in        <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (c == CMD_START)
        begin
            build_schedule();
            block_bytes = len & 16'hfff8;
            msg_pos     = 16'd0;
        end
        else
        begin
            res = cipher_byte(d);
            pending_bytes.push_back(typed ? typed_res : res);
        end
    endtask

    task automatic send_start(input logic [15:0] len);
        push_item(CMD_START, len, 8'($urandom), 1'b0, '0);
    endtask

    task automatic send_byte();
        push_item(CMD_DATA, 16'($urandom), 8'($urandom), 1'b0, '0);
    endtask

    // Key writes only once the block has drained and finished any schedule build.
    task automatic load_key(input logic [63:0] k);
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SCHED_CYCLES) @(posedge clk);
        key_we <= 1'b1;
        key    <= k;
        @(posedge clk);
        key_we <= 1'b0;
        key_reg = k;
    endtask

    function automatic logic [15:0] pick_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 16'($urandom_range(0, 40));
        else if (roll < 85)
            return 16'($urandom_range(41, 300));
        return 16'($urandom);
    endfunction

    task automatic run_phase(input int items, input int snd_pct, input int rcv_pct,
                             input bit press);
        int sent;
        int n;
        int roll;
        logic [15:0] len;
        sender_idle_pct = snd_pct;
        stall_pct <= rcv_pct;
        sent = 0;
        while (sent < items)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 85)
            begin
                len = pick_len();
                n = (len <= 16'd300) ? int'(len) + $urandom_range(0, 3)
                                     : $urandom_range(1, 280);
                send_start(len);
                for (int k = 0; k < n; k++)
                begin
                    if (press && k == 4)
                        hold_req_cnt <= hold_req_cnt + 1;
                    send_byte();
                end
                sent += n + 1;
            end
            else if (roll < 93)
            begin
                // stray bytes that continue the current message
                n = $urandom_range(1, 4);
                repeat (n) send_byte();
                sent += n;
            end
            else
            begin
                // message cut short by the next start
                len = 16'($urandom_range(16, 64));
                n = $urandom_range(0, int'(len) / 2);
                send_start(len);
                repeat (n) send_byte();
                sent += n + 1;
            end
        end
    endtask

    // receiver: random stall, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_ack_cnt != hold_req_cnt)
        begin
            hold_ack_cnt <= hold_req_cnt;
            hold_left    <= HOLD_CYCLES;
            out_stall    <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        byte_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bytes.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h", data_out));
            else
            begin
                want = pending_bytes.pop_front();
                check_field("data_out", data_out, want.dout);
                check_field("in_tail", {7'd0, in_tail}, {7'd0, want.tail});
                check_field("overrun", {7'd0, overrun}, {7'd0, want.over});
            end
        end
    end

    initial
    begin
        for (int cyc = 0; cyc < CYCLE_LIMIT; cyc++)
            @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        key_we          = 1'b0;
        key             = '0;
        in_valid        = 1'b0;
        cmd             = CMD_DATA;
        message_length  = '0;
        data_in         = '0;
        out_stall       = 1'b0;
        err_count       = 0;
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_req_cnt    = 0;
        hold_ack_cnt    = 0;
        hold_left       = 0;
        key_reg         = '0;
        perm_key        = '0;
        msg_pos         = '0;
        block_bytes     = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
        begin
            case (DIR_ROWS[i].kind)
                ROW_KEY:      load_key(DIR_ROWS[i].arg);
                ROW_START:    send_start(DIR_ROWS[i].arg[15:0]);
                ROW_BYTE:     push_item(CMD_DATA, 16'($urandom), DIR_ROWS[i].arg[7:0],
                                        1'b0, '0);
                ROW_BYTE_EXP: push_item(CMD_DATA, 16'($urandom), DIR_ROWS[i].arg[7:0],
                                        1'b1, DIR_ROWS[i].res);
                default: ;
            endcase
        end

        load_key({$urandom, $urandom});
        run_phase(RAND_ITEMS, 0, 0, 1'b0);
        load_key(64'h0);
        run_phase(RAND_ITEMS, 72, 0, 1'b0);
        load_key(64'hffff_ffff_ffff_ffff);
        run_phase(RAND_ITEMS, 0, 72, 1'b0);
        load_key({$urandom, $urandom});
        run_phase(RAND_ITEMS, 29, 29, 1'b0);
        load_key({$urandom, $urandom});
        run_phase(RAND_ITEMS, 0, 0, 1'b1);

        // one maximal-length message: full table, then overrun past its end
        load_key({$urandom, $urandom});
        sender_idle_pct = 0;
        stall_pct <= 0;
        send_start(16'hffff);
        repeat (LONG_BYTES) send_byte();

        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
